>>> src/rational_number_alu_defines.svh
// ----------------------------------------------------------------------------
// Rational number ALU assertion macros
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_NUMBER_ALU_DEFINES_SVH
`define RATIONAL_NUMBER_ALU_DEFINES_SVH

// Clocked assertion, disabled while reset is held
`define RNA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define RNA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/rna_pkg.sv
// ----------------------------------------------------------------------------
// Rational number ALU package
// Field widths, function codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rna_pkg;

    localparam int FUNC_BITS = 3;
    localparam int OPND_BITS = 32;
    localparam int RES_BITS  = 64;

    // Function codes
    localparam logic [FUNC_BITS-1:0] FN_ADD  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_SUB  = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_MUL  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_DIV  = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_MIN  = 3'd4;
    localparam logic [FUNC_BITS-1:0] FN_SIMP = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_CALC,
        S_GSTART,
        S_GWAIT,
        S_NSTART,
        S_NWAIT,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } state_t;

endpackage

>>> src/rna_mul.sv
// ----------------------------------------------------------------------------
// Rational number ALU multiplier
// Signed word by word multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rna_mul
    import rna_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    logic signed [2*W-1:0] p_reg;
    logic signed [2*W-1:0] p_next;

    // Form the full-width product
    assign p_next = a * b;

    // Capture the product when enabled, hold otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> src/rna_gcd.sv
// ----------------------------------------------------------------------------
// Rational number ALU gcd unit
// Binary gcd of two unsigned magnitudes, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rna_gcd
    import rna_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         done,
    output logic [W-1:0] g
);

    localparam int KW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  g_reg, g_next;
    logic          a_ge_b;
    logic [W-1:0]  diff;

    // Shared compare and subtract
    assign a_ge_b = a_reg >= b_reg;
    assign diff   = a_ge_b ? (a_reg - b_reg) : (b_reg - a_reg);

    // One gcd step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0)
            begin
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_ge_b)
            begin
                a_next = diff >> 1;
            end
            else
            begin
                b_next = diff >> 1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

>>> src/rna_div.sv
// ----------------------------------------------------------------------------
// Rational number ALU divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rna_div
    import rna_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    rem_sh;
    logic [W:0]    trial;
    logic          fits;

    // Trial subtract of the divisor from the shifted remainder
    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};
    assign trial  = rem_sh - {1'b0, dsr_reg};

    // One division step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[W-1:0] : rem_sh[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/rational_number_alu.sv
// Rational number ALU. Each transfer on the input channel carries a function
// code and two fractions; one result fraction with overflow and zero
// denominator flags comes back on the output channel. Only the low WORD_BITS
// bits of each operand are used, sign-extended. Add, sub, mul, div and min
// run their three cross products through a single WORD_BITS x WORD_BITS
// multiplier and step through S_MUL0, S_MUL1, S_MUL2, S_CALC and S_OUT.
// Simplify runs a binary gcd (at most about 2*WORD_BITS steps) followed by
// two restoring divisions of WORD_BITS steps each on one divider; a zero
// numerator and the unused codes go straight to S_CALC and S_OUT. The block
// takes one item at a time and accepts the next as soon as the previous
// result has moved into the output register, even while that result waits
// to be taken.
// ----------------------------------------------------------------------------
// Rational number ALU top level
// Sequencer, operand and result registers, and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_number_alu
    import rna_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [FUNC_BITS-1:0]        func,
    input  logic signed [OPND_BITS-1:0] num_a,
    input  logic signed [OPND_BITS-1:0] den_a,
    input  logic signed [OPND_BITS-1:0] num_b,
    input  logic signed [OPND_BITS-1:0] den_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [RES_BITS-1:0]  res_num,
    output logic signed [RES_BITS-1:0]  res_den,
    output logic                        overflow,
    output logic                        zero_den
);

    localparam int W = WORD_BITS;

    state_t                     state_reg, state_next;
    logic [FUNC_BITS-1:0]       func_reg;
    logic signed [W-1:0]        na_reg, da_reg, nb_reg, db_reg;
    logic signed [RES_BITS-1:0] prod0_reg, prod1_reg;
    logic [W-1:0]               qn_reg;
    logic [RES_BITS-1:0]        rn_reg, rd_reg;
    logic                       ovf_reg;
    logic [RES_BITS-1:0]        res_num_reg, res_den_reg;
    logic                       overflow_reg, zero_den_reg, out_valid_reg;

    logic                       accept;
    logic                       mul_en;
    logic signed [W-1:0]        mul_a, mul_b;
    logic signed [2*W-1:0]      mul_p;
    logic signed [RES_BITS-1:0] mul_p64;
    logic                       gcd_start, gcd_done;
    logic [W-1:0]               gcd_g;
    logic                       div_start, div_done;
    logic [W-1:0]               div_dividend, div_q;
    logic [W-1:0]               mag_na, mag_da;
    logic                       res_load, out_load;
    logic [RES_BITS-1:0]        sum, dif, qn_ext, qd_ext;
    logic [RES_BITS-1:0]        calc_rn, calc_rd;
    logic                       calc_ovf;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    rna_mul #(.W(W)) u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    rna_gcd #(.W(W)) u_gcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a_in  (mag_na),
        .b_in  (mag_da),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rna_div #(.W(W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_p64 = RES_BITS'(mul_p);
    assign mag_na  = na_reg[W-1] ? (~na_reg + 1'b1) : na_reg;
    assign mag_da  = da_reg[W-1] ? (~da_reg + 1'b1) : da_reg;
    assign accept  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((func == FN_SIMP) && (num_a[W-1:0] != '0))
                    begin
                        state_next = S_GSTART;
                    end
                    else if (func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MIN})
                    begin
                        state_next = S_MUL0;
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_MUL0:   state_next = S_MUL1;
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_CALC;
            S_CALC:   state_next = S_OUT;
            S_GSTART: state_next = S_GWAIT;
            S_GWAIT:
            begin
                if (gcd_done)
                begin
                    state_next = S_NSTART;
                end
            end
            S_NSTART: state_next = S_NWAIT;
            S_NWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DSTART;
                end
            end
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready     = 1'b0;
        mul_en       = 1'b0;
        mul_a        = na_reg;
        mul_b        = db_reg;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = mag_na;
        res_load     = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_MUL0:
            begin
                mul_en = 1'b1;
                if (func_reg == FN_MUL)
                begin
                    mul_b = nb_reg;
                end
            end
            S_MUL1:
            begin
                mul_en = 1'b1;
                if ((func_reg == FN_ADD) || (func_reg == FN_SUB))
                begin
                    mul_a = nb_reg;
                    mul_b = da_reg;
                end
                else if (func_reg == FN_MUL)
                begin
                    mul_a = da_reg;
                    mul_b = db_reg;
                end
                else
                begin
                    mul_a = da_reg;
                    mul_b = nb_reg;
                end
            end
            S_MUL2:
            begin
                mul_en = 1'b1;
                mul_a  = da_reg;
                mul_b  = db_reg;
            end
            S_CALC:
            begin
                res_load = 1'b1;
            end
            S_GSTART:
            begin
                gcd_start = 1'b1;
            end
            S_NSTART:
            begin
                div_start = 1'b1;
            end
            S_DSTART:
            begin
                div_start    = 1'b1;
                div_dividend = mag_da;
            end
            S_DWAIT:
            begin
                div_dividend = mag_da;
                res_load     = div_done;
            end
            S_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result combine
    // ------------------------------------------------------------------
    assign sum    = prod0_reg + prod1_reg;
    assign dif    = prod0_reg - prod1_reg;
    assign qn_ext = RES_BITS'(qn_reg);
    assign qd_ext = RES_BITS'(div_q);

    always_comb
    begin
        calc_rn  = '0;
        calc_rd  = RES_BITS'(1);
        calc_ovf = 1'b0;
        if (state_reg == S_DWAIT)
        begin
            // Reduced fraction, signs restored
            calc_rn = na_reg[W-1] ? ('0 - qn_ext) : qn_ext;
            calc_rd = da_reg[W-1] ? ('0 - qd_ext) : qd_ext;
        end
        else
        begin
            case (func_reg)
                FN_ADD:
                begin
                    calc_rn  = sum;
                    calc_rd  = mul_p64;
                    calc_ovf = (prod0_reg[RES_BITS-1] == prod1_reg[RES_BITS-1]) &&
                               (sum[RES_BITS-1] != prod0_reg[RES_BITS-1]);
                end
                FN_SUB:
                begin
                    calc_rn  = dif;
                    calc_rd  = mul_p64;
                    calc_ovf = (prod0_reg[RES_BITS-1] != prod1_reg[RES_BITS-1]) &&
                               (dif[RES_BITS-1] != prod0_reg[RES_BITS-1]);
                end
                FN_MUL, FN_DIV:
                begin
                    calc_rn = prod0_reg;
                    calc_rd = prod1_reg;
                end
                FN_MIN:
                begin
                    if (prod0_reg <= prod1_reg)
                    begin
                        calc_rn = RES_BITS'(na_reg);
                        calc_rd = RES_BITS'(da_reg);
                    end
                    else
                    begin
                        calc_rn = RES_BITS'(nb_reg);
                        calc_rd = RES_BITS'(db_reg);
                    end
                end
                default:
                begin
                    // Zero numerator simplify and unused codes give 0/1
                    calc_rn = '0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Capture operands on transfer
        if (accept)
        begin
            func_reg <= func;
            na_reg   <= num_a[W-1:0];
            da_reg   <= den_a[W-1:0];
            nb_reg   <= num_b[W-1:0];
            db_reg   <= den_b[W-1:0];
        end
        // Hold cross products
        if (state_reg == S_MUL1)
        begin
            prod0_reg <= mul_p64;
        end
        if (state_reg == S_MUL2)
        begin
            prod1_reg <= mul_p64;
        end
        // Hold reduced numerator magnitude
        if ((state_reg == S_NWAIT) && div_done)
        begin
            qn_reg <= div_q;
        end
        if (res_load)
        begin
            rn_reg  <= calc_rn;
            rd_reg  <= calc_rd;
            ovf_reg <= calc_ovf;
        end
        if (out_load)
        begin
            res_num_reg  <= rn_reg;
            res_den_reg  <= rd_reg;
            overflow_reg <= ovf_reg;
            zero_den_reg <= (rd_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign overflow  = overflow_reg;
    assign zero_den  = zero_den_reg;

endmodule

>>> src/rna_checker.sv
// ----------------------------------------------------------------------------
// Rational number ALU port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_number_alu_defines.svh"

module rna_checker
    import rna_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [RES_BITS-1:0] res_num,
    input  logic signed [RES_BITS-1:0] res_den,
    input  logic                       zero_den
);

    // Stalled result holds its payload
    `RNA_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den)), "stalled result changed")

    // Zero denominator flag agrees with the denominator
    `RNA_ASSERT(a_zero_den, (out_valid |-> (zero_den == (res_den == '0))), "zero_den mismatch")

    // Block is busy right after taking an item
    `RNA_ASSERT(a_busy, (in_valid && in_ready |=> !in_ready), "ready right after input transfer")

    // No result is offered during reset
    `RNA_ASSERT_ALWAYS(a_rst_idle, (!rst_n |-> !out_valid), "result valid in reset")

endmodule

bind rational_number_alu rna_checker u_rna_checker (.*);

>>> tb/sv/rational_number_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational number ALU testbench
// Sends function codes with fraction operands over the input channel and
// predicts each result fraction, with its overflow and zero denominator flags.
// Each result is checked field by field, in order. The run covers directed
// corner cases, a long output hold-off, and random traffic under three
// idling patterns.
// ----------------------------------------------------------------------------

module rational_number_alu_tb;

    import rna_pkg::*;

    localparam int WORD_BITS  = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 150;

    // Function codes the block leaves unused
    localparam logic [FUNC_BITS-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_BITS-1:0] FN_SPARE7 = 3'd7;

    // Operand corner values
    localparam logic [OPND_BITS-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [OPND_BITS-1:0] W_MAX  = 32'h7fff_ffff;
    localparam logic [OPND_BITS-1:0] W_NEG1 = 32'hffff_ffff;

    typedef struct packed {
        logic [RES_BITS-1:0] num;
        logic [RES_BITS-1:0] den;
        logic                ovf;
        logic                zden;
    } fraction_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [FUNC_BITS-1:0]        func;
    logic signed [OPND_BITS-1:0] num_a;
    logic signed [OPND_BITS-1:0] den_a;
    logic signed [OPND_BITS-1:0] num_b;
    logic signed [OPND_BITS-1:0] den_b;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [RES_BITS-1:0]  res_num;
    logic signed [RES_BITS-1:0]  res_den;
    logic                        overflow;
    logic                        zero_den;

    fraction_t fractions_due[$];
    fraction_t owed;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        rx_hold_len = 0;

    rational_number_alu #(
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den),
        .overflow  (overflow),
        .zero_den  (zero_den)
    );

    // Run the clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sign-extend the low WORD_BITS bits of an operand
    function automatic longint widen(input logic [OPND_BITS-1:0] v);
        logic [63:0] x;
        x = {32'd0, v} & ((64'd1 << WORD_BITS) - 64'd1);
        if (x[WORD_BITS-1])
            x = x - (64'd1 << WORD_BITS);
        return longint'(x);
    endfunction

    // Work out the result fraction and flags for one operation
    function automatic fraction_t compute_fraction(
        input logic [FUNC_BITS-1:0] fn,
        input logic [OPND_BITS-1:0] an,
        input logic [OPND_BITS-1:0] ad,
        input logic [OPND_BITS-1:0] bn,
        input logic [OPND_BITS-1:0] bd
    );
        longint          na, da, nb, db, p1, p2, sum;
        longint unsigned mn, md, ga, gb, t;
        fraction_t       r;
        na = widen(an);
        da = widen(ad);
        nb = widen(bn);
        db = widen(bd);
        r.num = 64'd0;
        r.den = 64'd1;
        r.ovf = 1'b0;
        case (fn)
            FN_ADD, FN_SUB:
            begin
                p1 = na * db;
                p2 = nb * da;
                if (fn == FN_ADD)
                begin
                    sum   = p1 + p2;
                    r.ovf = (p1[63] == p2[63]) && (sum[63] != p1[63]);
                end
                else
                begin
                    sum   = p1 - p2;
                    r.ovf = (p1[63] != p2[63]) && (sum[63] != p1[63]);
                end
                r.num = sum;
                r.den = da * db;
            end
            FN_MUL:
            begin
                r.num = na * nb;
                r.den = da * db;
            end
            FN_DIV:
            begin
                r.num = na * db;
                r.den = da * nb;
            end
            FN_MIN:
            begin
                if (na * db <= da * nb)
                begin
                    r.num = na;
                    r.den = da;
                end
                else
                begin
                    r.num = nb;
                    r.den = db;
                end
            end
            FN_SIMP:
            begin
                // Reduce by the gcd of the magnitudes; a zero numerator keeps 0/1
                if (na != 0)
                begin
                    mn = (na < 0) ? -na : na;
                    md = (da < 0) ? -da : da;
                    ga = mn;
                    gb = md;
                    while (gb != 0)
                    begin
                        t  = ga % gb;
                        ga = gb;
                        gb = t;
                    end
                    r.num = (na < 0) ? -(mn / ga) : (mn / ga);
                    r.den = (da < 0) ? -(md / ga) : (md / ga);
                end
            end
            default:
            begin
            end
        endcase
        r.zden = (r.den == 64'd0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Check each result transfer against the oldest owed fraction, then log
    // each input transfer as a new owed fraction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (fractions_due.size() == 0)
                    report_mismatch($sformatf("result %h/%h with none owed", res_num, res_den));
                else
                begin
                    owed = fractions_due.pop_front();
                    if (res_num !== owed.num)
                        report_mismatch($sformatf("res_num %h, want %h", res_num, owed.num));
                    if (res_den !== owed.den)
                        report_mismatch($sformatf("res_den %h, want %h", res_den, owed.den));
                    if (overflow !== owed.ovf)
                        report_mismatch($sformatf("overflow %b, want %b", overflow, owed.ovf));
                    if (zero_den !== owed.zden)
                        report_mismatch($sformatf("zero_den %b, want %b", zero_den, owed.zden));
                end
            end
            if (in_valid && in_ready)
                fractions_due.push_back(compute_fraction(func, num_a, den_a, num_b, den_b));
        end
    end

    // Drop out_ready at random, or for a requested hold-off stretch
    initial
    begin
        int hold;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                out_ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("rational_number_alu_tb: FAIL");
            $finish;
        end
    end

    // Offer one operation, with a random gap first, and hold it until transfer
    task automatic send_operation(
        input logic [FUNC_BITS-1:0] fn,
        input logic [OPND_BITS-1:0] an,
        input logic [OPND_BITS-1:0] ad,
        input logic [OPND_BITS-1:0] bn,
        input logic [OPND_BITS-1:0] bd
    );
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        num_a    <= an;
        den_a    <= ad;
        num_b    <= bn;
        den_b    <= bd;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop offering and wait until every owed fraction has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (fractions_due.size() != 0)
            @(posedge clk);
    endtask

    // Pick an operand: full range, small, corner, half-width or a power of two of either sign
    function automatic logic [OPND_BITS-1:0] pick_operand();
        logic [OPND_BITS-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0, 1: ;
            2: r = $urandom_range(0, 40) - 20;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: r = W_MIN;
                    1: r = W_MAX;
                    2: r = '0;
                    3: r = W_NEG1;
                    default: r = 32'd1;
                endcase
            end
            4: r = {{16{r[15]}}, r[15:0]};
            5: r = 32'd1 << $urandom_range(0, 31);
            default: r = -(32'd1 << $urandom_range(0, 30));
        endcase
        return r;
    endfunction

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Plain arithmetic on small fractions
        send_operation(FN_ADD, 1, 2, 1, 3);
        send_operation(FN_SUB, 1, 2, 1, 3);
        send_operation(FN_MUL, -3, 4, 5, -7);
        send_operation(FN_DIV, 3, 4, 5, 7);
        send_operation(FN_ADD, W_NEG1, W_NEG1, W_NEG1, W_NEG1);
        // Add numerator past the top of the signed range, then extreme sub and mul and zero denominators
        send_operation(FN_ADD, W_MIN, W_MIN, W_MIN, W_MIN);
        send_operation(FN_SUB, W_MIN, W_MIN, W_MIN, W_MAX);
        send_operation(FN_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
        send_operation(FN_MUL, W_MAX, 0, W_MAX, 5);
        send_operation(FN_DIV, 7, 3, 0, 9);
        // Min: A smaller, equal, larger, negative denominators
        send_operation(FN_MIN, 1, 3, 1, 2);
        send_operation(FN_MIN, 2, 4, 1, 2);
        send_operation(FN_MIN, 5, 6, 1, 2);
        send_operation(FN_MIN, 1, -3, 1, 2);
        send_operation(FN_MIN, W_MAX, W_MIN, W_MIN, W_MAX);
        // Simplify: signs, zero numerator, zero denominator, extremes
        send_operation(FN_SIMP, 12, -18, 0, 0);
        send_operation(FN_SIMP, 0, 5, 3, 4);
        send_operation(FN_SIMP, 0, 0, 0, 0);
        send_operation(FN_SIMP, -7, 0, 1, 1);
        send_operation(FN_SIMP, W_MIN, W_MIN, W_NEG1, W_NEG1);
        send_operation(FN_SIMP, W_MAX, W_MAX, 0, 0);
        send_operation(FN_SIMP, W_NEG1, W_MIN, 0, 0);
        // Unused codes give 0/1
        send_operation(FN_SPARE6, W_MAX, 2, 3, 4);
        send_operation(FN_SPARE7, W_NEG1, W_NEG1, W_NEG1, W_NEG1);
        drain_results();
    endtask

    // Hold the output off while items keep coming, so the input stalls
    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = 300;
        repeat (8)
            send_operation(FUNC_BITS'($urandom_range(0, 4)), pick_operand(), pick_operand(),
                           pick_operand(), pick_operand());
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int                   sel;
        logic [FUNC_BITS-1:0] fn;
        logic [OPND_BITS-1:0] an, ad, bn, bd;
        int                   g;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count)
        begin
            sel = $urandom_range(99);
            an  = pick_operand();
            ad  = pick_operand();
            bn  = pick_operand();
            bd  = pick_operand();
            if (sel < 70)
                fn = FUNC_BITS'($urandom_range(0, 4));
            else if (sel < 94)
            begin
                fn = FN_SIMP;
                // Build a shared factor half the time so the gcd is nontrivial
                if ($urandom_range(1))
                begin
                    g  = $urandom_range(1, 5000);
                    an = g * $urandom_range(0, 400000);
                    ad = g * $urandom_range(0, 400000);
                    if ($urandom_range(1))
                        an = -an;
                    if ($urandom_range(1))
                        ad = -ad;
                end
            end
            else
                fn = $urandom_range(1) ? FN_SPARE6 : FN_SPARE7;
            send_operation(fn, an, ad, bn, bd);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= FN_ADD;
        num_a    <= '0;
        den_a    <= '0;
        num_b    <= '0;
        den_b    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_hold_off();
        test_random_traffic(22, 66, 500);
        test_random_traffic(66, 22, 500);
        test_random_traffic(0, 0, 480);

        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0 && fractions_due.size() == 0)
            $display("rational_number_alu_tb: PASS");
        else
            $display("rational_number_alu_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/rna_pkg.sv
src/rna_mul.sv
src/rna_gcd.sv
src/rna_div.sv
src/rational_number_alu.sv
src/rna_checker.sv
tb/sv/rational_number_alu_tb.sv
